@@ rtl/mfps_pkg.sv @@
// Shared types and codes for the message FIFO with resume offset.
// No dependencies; every other file in rtl/ but mfps_ram imports this package.
package mfps_pkg;

    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int MESSAGE_BYTES_DEF = 1024;
    localparam int STAT_W            = 32;
    localparam int COUNT_W           = 16;

    typedef logic [2:0] t_action;
    localparam t_action ACT_PUSH = 3'd0;
    localparam t_action ACT_READ = 3'd1;
    localparam t_action ACT_POP  = 3'd2;
    localparam t_action ACT_ADV  = 3'd3;
    localparam t_action ACT_DROP = 3'd4;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_EMPTY = 3'd1;
    localparam t_status ST_FULL  = 3'd2;
    localparam t_status ST_LARGE = 3'd3;
    localparam t_status ST_RANGE = 3'd4;

    typedef enum logic [1:0] {
        DISC_NONE,
        DISC_LARGE,
        DISC_FULL
    } t_disc;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NEXT,
        S_BYTE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic pushed;
        logic popped;
        logic dropped;
        logic partial;
    } t_stat_inc;

endpackage

@@ rtl/mfps_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; used for the byte store and the head metadata store.
module mfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mfps_stats.sv @@
// Four 32-bit wrapping statistics counters (pushed, popped, dropped, partial).
// Depends on mfps_pkg for the increment struct.
module mfps_stats (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mfps_pkg::t_stat_inc              i_inc,
    output logic [mfps_pkg::STAT_W-1:0]      o_pushed,
    output logic [mfps_pkg::STAT_W-1:0]      o_popped,
    output logic [mfps_pkg::STAT_W-1:0]      o_dropped,
    output logic [mfps_pkg::STAT_W-1:0]      o_partial
);
    import mfps_pkg::*;

    logic [STAT_W-1:0] r_pushed, n_pushed;
    logic [STAT_W-1:0] r_popped, n_popped;
    logic [STAT_W-1:0] r_dropped, n_dropped;
    logic [STAT_W-1:0] r_partial, n_partial;

    always_comb begin
        n_pushed  = r_pushed  + STAT_W'(i_inc.pushed);
        n_popped  = r_popped  + STAT_W'(i_inc.popped);
        n_dropped = r_dropped + STAT_W'(i_inc.dropped);
        n_partial = r_partial + STAT_W'(i_inc.partial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pushed  <= '0;
            r_popped  <= '0;
            r_dropped <= '0;
            r_partial <= '0;
        end else begin
            r_pushed  <= n_pushed;
            r_popped  <= n_popped;
            r_dropped <= n_dropped;
            r_partial <= n_partial;
        end
    end

    assign o_pushed  = r_pushed;
    assign o_popped  = r_popped;
    assign o_dropped = r_dropped;
    assign o_partial = r_partial;

endmodule

@@ rtl/mfps_seq.sv @@
// Sequencer for the message ring: ring pointers, push assembly and the
// read-modify-write of head metadata. Depends on mfps_pkg; drives both RAMs.
module mfps_seq #(
    parameter int QUEUE_DEPTH   = mfps_pkg::QUEUE_DEPTH_DEF,
    parameter int MESSAGE_BYTES = mfps_pkg::MESSAGE_BYTES_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  mfps_pkg::t_action                        i_action,
    input  logic [7:0]                               i_data_byte,
    input  logic                                     i_last_byte,
    input  logic [$clog2(MESSAGE_BYTES)-1:0]         i_read_index,
    input  logic [mfps_pkg::COUNT_W-1:0]             i_advance_count,
    output logic                                     o_meta_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]           o_meta_waddr,
    output logic [2*$clog2(MESSAGE_BYTES+1)-1:0]     o_meta_wdata,
    output logic                                     o_meta_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]           o_meta_raddr,
    input  logic [2*$clog2(MESSAGE_BYTES+1)-1:0]     i_meta_rdata,
    output logic                                     o_byte_we,
    output logic [$clog2(QUEUE_DEPTH*MESSAGE_BYTES)-1:0] o_byte_waddr,
    output logic [7:0]                               o_byte_wdata,
    output logic                                     o_byte_re,
    output logic [$clog2(QUEUE_DEPTH*MESSAGE_BYTES)-1:0] o_byte_raddr,
    input  logic [7:0]                               i_byte_rdata,
    output mfps_pkg::t_stat_inc                      o_stat_inc,
    input  logic                                     i_out_free,
    output logic                                     o_res_valid,
    output mfps_pkg::t_status                        o_res_status,
    output logic [7:0]                               o_res_read_byte,
    output logic [$clog2(MESSAGE_BYTES+1)-1:0]       o_res_remaining,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         o_res_queued
);
    import mfps_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(MESSAGE_BYTES + 1);
    localparam int IW = $clog2(MESSAGE_BYTES);
    localparam int AW = $clog2(QUEUE_DEPTH * MESSAGE_BYTES);

    t_state            r_state, n_state;
    t_action           r_action, n_action;
    logic [7:0]        r_data, n_data;
    logic              r_last, n_last;
    logic [IW-1:0]     r_index, n_index;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PW-1:0]     r_head, n_head;
    logic [PW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_msgs, n_msgs;
    logic [LW-1:0]     r_fill, n_fill;
    t_disc             r_disc, n_disc;
    t_status           r_res_status, n_res_status;
    logic [7:0]        r_res_read_byte, n_res_read_byte;
    logic [LW-1:0]     r_res_remaining, n_res_remaining;
    logic [CW-1:0]     r_res_queued, n_res_queued;

    logic              accept;
    logic [LW-1:0]     len_h, off_h, rem_h, pos_h;
    logic              nonempty, is_full, fill_ok, read_ok, adv_done, take_head;
    t_disc             push_disc;
    logic [LW-1:0]     push_fill_n;
    logic [PW-1:0]     head_nxt, tail_nxt;
    logic [CW-1:0]     msgs_dec;

    assign accept = i_in_valid && !o_in_stall;

    // decisions taken in the execute cycle from the head metadata
    always_comb begin
        len_h    = i_meta_rdata[2*LW-1:LW];
        off_h    = i_meta_rdata[LW-1:0];
        rem_h    = len_h - off_h;
        pos_h    = off_h + LW'(r_index);
        nonempty = (r_msgs != '0);
        is_full  = (r_msgs == CW'(QUEUE_DEPTH));
        fill_ok  = (r_fill < LW'(MESSAGE_BYTES));
        read_ok  = (LW'(r_index) < rem_h);
        adv_done = (r_count >= COUNT_W'(rem_h));
        head_nxt = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
        tail_nxt = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PW'(1);
        msgs_dec = r_msgs - CW'(1);
        push_disc   = r_disc;
        push_fill_n = r_fill;
        if (!fill_ok) begin
            push_disc = DISC_LARGE;
        end else if (is_full) begin
            push_disc   = (r_disc == DISC_NONE) ? DISC_FULL : r_disc;
            push_fill_n = r_fill + LW'(1);
        end else begin
            push_fill_n = r_fill + LW'(1);
        end
        take_head = nonempty && ((r_action == ACT_POP) ||
                                 ((r_action == ACT_ADV) && adv_done) ||
                                 ((r_action == ACT_DROP) && (off_h != '0)));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if ((r_action == ACT_READ) && nonempty && read_ok) begin
                    n_state = S_BYTE;
                end else if (take_head && (msgs_dec != '0)) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_NEXT:  n_state = S_OUT;
            S_BYTE:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_res_valid     = (r_state == S_OUT);
        o_meta_we       = 1'b0;
        o_meta_waddr    = r_tail;
        o_meta_wdata    = {push_fill_n, LW'(0)};
        o_meta_re       = 1'b0;
        o_meta_raddr    = r_head;
        o_byte_we       = 1'b0;
        o_byte_waddr    = AW'(r_tail) * AW'(MESSAGE_BYTES) + AW'(r_fill);
        o_byte_wdata    = r_data;
        o_byte_re       = 1'b0;
        o_byte_raddr    = AW'(r_head) * AW'(MESSAGE_BYTES) + AW'(pos_h);
        o_stat_inc      = '0;
        n_action        = r_action;
        n_data          = r_data;
        n_last          = r_last;
        n_index         = r_index;
        n_count         = r_count;
        n_head          = r_head;
        n_tail          = r_tail;
        n_msgs          = r_msgs;
        n_fill          = r_fill;
        n_disc          = r_disc;
        n_res_status    = r_res_status;
        n_res_read_byte = r_res_read_byte;
        n_res_remaining = r_res_remaining;
        n_res_queued    = r_res_queued;
        unique case (r_state)
            S_IDLE: begin
                // keep the head metadata fresh for the execute cycle
                o_meta_re = 1'b1;
                if (accept) begin
                    n_action = i_action;
                    n_data   = i_data_byte;
                    n_last   = i_last_byte;
                    n_index  = i_read_index;
                    n_count  = i_advance_count;
                end
            end
            S_EXEC: begin
                n_res_status    = ST_OK;
                n_res_read_byte = '0;
                n_res_remaining = nonempty ? rem_h : '0;
                unique case (r_action)
                    ACT_PUSH: begin
                        n_fill    = push_fill_n;
                        n_disc    = push_disc;
                        o_byte_we = fill_ok && !is_full;
                        if (r_last) begin
                            n_fill = '0;
                            n_disc = DISC_NONE;
                            if (push_disc == DISC_LARGE) begin
                                n_res_status       = ST_LARGE;
                                o_stat_inc.dropped = 1'b1;
                            end else if ((push_disc == DISC_FULL) || is_full) begin
                                n_res_status       = ST_FULL;
                                o_stat_inc.dropped = 1'b1;
                            end else begin
                                o_meta_we         = 1'b1;
                                n_tail            = tail_nxt;
                                n_msgs            = r_msgs + CW'(1);
                                o_stat_inc.pushed = 1'b1;
                                if (!nonempty) n_res_remaining = push_fill_n;
                            end
                        end
                    end
                    ACT_READ: begin
                        if (!nonempty) begin
                            n_res_status = ST_EMPTY;
                        end else if (!read_ok) begin
                            n_res_status = ST_RANGE;
                        end else begin
                            o_byte_re = 1'b1;
                        end
                    end
                    ACT_POP, ACT_ADV, ACT_DROP: begin
                        if (!nonempty) begin
                            n_res_status = ST_EMPTY;
                        end else if (take_head) begin
                            n_head          = head_nxt;
                            n_msgs          = msgs_dec;
                            n_res_remaining = '0;
                            o_meta_re       = (msgs_dec != '0);
                            o_meta_raddr    = head_nxt;
                            if (r_action == ACT_DROP) begin
                                o_stat_inc.dropped = 1'b1;
                            end else begin
                                o_stat_inc.popped = 1'b1;
                            end
                        end else if (r_action == ACT_ADV) begin
                            // short advance: move the resume offset
                            o_meta_we          = 1'b1;
                            o_meta_waddr       = r_head;
                            o_meta_wdata       = {len_h, off_h + LW'(r_count)};
                            o_stat_inc.partial = 1'b1;
                            n_res_remaining    = rem_h - LW'(r_count);
                        end
                    end
                    default: begin
                    end
                endcase
                n_res_queued = n_msgs;
            end
            S_NEXT: begin
                n_res_remaining = rem_h;
            end
            S_BYTE: begin
                n_res_read_byte = i_byte_rdata;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_msgs  <= '0;
            r_fill  <= '0;
            r_disc  <= DISC_NONE;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_msgs  <= n_msgs;
            r_fill  <= n_fill;
            r_disc  <= n_disc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action        <= n_action;
        r_data          <= n_data;
        r_last          <= n_last;
        r_index         <= n_index;
        r_count         <= n_count;
        r_res_status    <= n_res_status;
        r_res_read_byte <= n_res_read_byte;
        r_res_remaining <= n_res_remaining;
        r_res_queued    <= n_res_queued;
    end

    assign o_res_status    = r_res_status;
    assign o_res_read_byte = r_res_read_byte;
    assign o_res_remaining = r_res_remaining;
    assign o_res_queued    = r_res_queued;

endmodule

@@ rtl/message_fifo_partial_send.sv @@
// Top level of the message FIFO with resume offset: sequencer, byte store,
// head metadata store, statistics and the output register. Uses mfps_pkg.
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall | action, byte, last, index, count
//  out     | output    | o_out_valid / i_out_stall | status, byte, remaining, totals
//
//  An item passes accept, execute and result, with a step between execute
//  and result when a second memory read is needed: a read fetches the byte,
//  and a pop that leaves messages behind fetches the new head's length and
//  offset. Each step waits on the registered metadata read before it modifies it.
//  Reset is synchronous and active low; it clears pointers, counts, push
//  state and counters, the RAM contents stay undefined until written.
//  A stalled result holds in the output register; the next item is taken
//  meanwhile and waits finished until that register frees.
module message_fifo_partial_send #(
    parameter int QUEUE_DEPTH   = mfps_pkg::QUEUE_DEPTH_DEF,
    parameter int MESSAGE_BYTES = mfps_pkg::MESSAGE_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  mfps_pkg::t_action                    i_action,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_last_byte,
    input  logic [$clog2(MESSAGE_BYTES)-1:0]     i_read_index,
    input  logic [mfps_pkg::COUNT_W-1:0]         i_advance_count,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output mfps_pkg::t_status                    o_status,
    output logic [7:0]                           o_read_byte,
    output logic [$clog2(MESSAGE_BYTES+1)-1:0]   o_remaining_len,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_queued,
    output logic [mfps_pkg::STAT_W-1:0]          o_pushed_total,
    output logic [mfps_pkg::STAT_W-1:0]          o_popped_total,
    output logic [mfps_pkg::STAT_W-1:0]          o_dropped_total,
    output logic [mfps_pkg::STAT_W-1:0]          o_partial_total
);
    import mfps_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(MESSAGE_BYTES + 1);
    localparam int AW = $clog2(QUEUE_DEPTH * MESSAGE_BYTES);

    logic              meta_we, meta_re;
    logic [PW-1:0]     meta_waddr, meta_raddr;
    logic [2*LW-1:0]   meta_wdata, meta_rdata;
    logic              byte_we, byte_re;
    logic [AW-1:0]     byte_waddr, byte_raddr;
    logic [7:0]        byte_wdata, byte_rdata;
    t_stat_inc         stat_inc;
    logic              out_free, res_valid, load;
    t_status           res_status;
    logic [7:0]        res_read_byte;
    logic [LW-1:0]     res_remaining;
    logic [CW-1:0]     res_queued;
    logic [STAT_W-1:0] cnt_pushed, cnt_popped, cnt_dropped, cnt_partial;

    logic              r_out_valid, n_out_valid;
    t_status           r_status;
    logic [7:0]        r_read_byte;
    logic [LW-1:0]     r_remaining;
    logic [CW-1:0]     r_queued;
    logic [STAT_W-1:0] r_pushed, r_popped, r_dropped, r_partial;

    mfps_seq #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_read_index    (i_read_index),
        .i_advance_count (i_advance_count),
        .o_meta_we       (meta_we),
        .o_meta_waddr    (meta_waddr),
        .o_meta_wdata    (meta_wdata),
        .o_meta_re       (meta_re),
        .o_meta_raddr    (meta_raddr),
        .i_meta_rdata    (meta_rdata),
        .o_byte_we       (byte_we),
        .o_byte_waddr    (byte_waddr),
        .o_byte_wdata    (byte_wdata),
        .o_byte_re       (byte_re),
        .o_byte_raddr    (byte_raddr),
        .i_byte_rdata    (byte_rdata),
        .o_stat_inc      (stat_inc),
        .i_out_free      (out_free),
        .o_res_valid     (res_valid),
        .o_res_status    (res_status),
        .o_res_read_byte (res_read_byte),
        .o_res_remaining (res_remaining),
        .o_res_queued    (res_queued)
    );

    mfps_ram #(
        .WIDTH (2 * LW),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    mfps_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH * MESSAGE_BYTES)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_re    (byte_re),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    mfps_stats u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inc     (stat_inc),
        .o_pushed  (cnt_pushed),
        .o_popped  (cnt_popped),
        .o_dropped (cnt_dropped),
        .o_partial (cnt_partial)
    );

    // output register: load a finished result once the previous beat is gone
    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        load        = res_valid && out_free;
        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status    <= res_status;
            r_read_byte <= res_read_byte;
            r_remaining <= res_remaining;
            r_queued    <= res_queued;
            r_pushed    <= cnt_pushed;
            r_popped    <= cnt_popped;
            r_dropped   <= cnt_dropped;
            r_partial   <= cnt_partial;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_read_byte     = r_read_byte;
    assign o_remaining_len = r_remaining;
    assign o_queued        = r_queued;
    assign o_pushed_total  = r_pushed;
    assign o_popped_total  = r_popped;
    assign o_dropped_total = r_dropped;
    assign o_partial_total = r_partial;

endmodule

@@ rtl/mfps_checker.sv @@
// Port-level checks for message_fifo_partial_send, bound to the top level.
// Depends on mfps_pkg for the status codes.
module mfps_checker #(
    parameter int QUEUE_DEPTH   = mfps_pkg::QUEUE_DEPTH_DEF,
    parameter int MESSAGE_BYTES = mfps_pkg::MESSAGE_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_stall,
    input  mfps_pkg::t_action                    i_action,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_last_byte,
    input  logic [$clog2(MESSAGE_BYTES)-1:0]     i_read_index,
    input  logic [mfps_pkg::COUNT_W-1:0]         i_advance_count,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  mfps_pkg::t_status                    o_status,
    input  logic [7:0]                           o_read_byte,
    input  logic [$clog2(MESSAGE_BYTES+1)-1:0]   o_remaining_len,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_queued,
    input  logic [mfps_pkg::STAT_W-1:0]          o_pushed_total,
    input  logic [mfps_pkg::STAT_W-1:0]          o_popped_total,
    input  logic [mfps_pkg::STAT_W-1:0]          o_dropped_total,
    input  logic [mfps_pkg::STAT_W-1:0]          o_partial_total
);
    import mfps_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_remaining_len) && $stable(o_pushed_total))
        else $error("stalled result beat changed");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_queued <= CW'(QUEUE_DEPTH))
        else $error("queue depth beyond capacity");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_queued == '0) |-> o_remaining_len == '0)
        else $error("remaining length on an empty ring");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_queued == '0)
        else $error("empty status with messages queued");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_byte != 8'd0) |-> o_status == ST_OK)
        else $error("read byte returned with a failing status");

endmodule

bind message_fifo_partial_send mfps_checker #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MESSAGE_BYTES (MESSAGE_BYTES)
) u_mfps_checker (.*);
